// ----- rtl/prtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtp_pkg
// Shared types and constants of the probe record text parser.
// ----------------------------------------------------------------------------
package prtp_pkg;

   localparam int ID_BYTES   = 32;
   localparam int ID_SLOTS   = 32;
   localparam int ID_IDX_W   = $clog2(ID_SLOTS);
   localparam int NUM_DEC    = 5;
   localparam int CHUNK_BYTES = 8;

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [3:0] FIELD_TIME    = 4'd1;
   localparam logic [3:0] FIELD_ID      = 4'd3;
   localparam logic [3:0] FIELD_LAT     = 4'd4;
   localparam logic [3:0] FIELD_LON     = 4'd5;
   localparam logic [3:0] FIELD_SPEED   = 4'd6;
   localparam logic [3:0] FIELD_HEADING = 4'd7;
   localparam logic [3:0] FIELD_MAX     = 4'd15;
   localparam logic [3:0] FIELD_MIN_OK  = 4'd2;

   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   localparam logic [6:0] HEX_LIMIT = 7'(2 * ID_BYTES);
   localparam logic [6:0] HEX_SAT   = 7'd64;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic               record_valid;
      logic signed [31:0] time_stamp;
      logic signed [31:0] latitude_raw;
      logic signed [31:0] longitude_raw;
      logic signed [31:0] speed_value;
      logic signed [31:0] heading_value;
      logic [63:0]        id_chunk;
      logic [1:0]         chunk_index;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic                          record_valid;
      logic [NUM_DEC-1:0][31:0]      dec;
      logic [ID_SLOTS-1:0][7:0]      id;
   } snap_type;

endpackage

// ----- rtl/prtp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtp_parser
// Input register and per-byte field parser; hands a record snapshot to the
// emitter at each line end.
// ----------------------------------------------------------------------------
module prtp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  prtp_pkg::req_type  req_data,
   output logic               snap_valid,
   input  logic               snap_ready,
   output prtp_pkg::snap_type snap_data
);

   logic                                   in_valid_ff;
   prtp_pkg::req_type                      in_ff;
   logic [3:0]                             field_ff, field_in;
   logic                                   tok_ff, tok_in;
   logic [31:0]                            acc_ff, acc_in;
   logic [1:0]                             phase_ff, phase_in;
   logic                                   neg_ff, neg_in;
   logic [6:0]                             hc_ff, hc_in;
   logic                                   ended_ff, ended_in;
   logic [prtp_pkg::ID_SLOTS-1:0][3:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [prtp_pkg::NUM_DEC-1:0][31:0]     dec_ff, dec_in;
   logic                                   step;
   logic [7:0]                             b;
   logic                                   is_dec;
   logic [2:0]                             slot;
   logic [35:0]                            mag;
   logic [prtp_pkg::ID_IDX_W-1:0]          idx;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
      else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
      return n;
   endfunction

   assign b          = in_ff.byte_value;
   assign step       = in_valid_ff && (!in_ff.line_end || snap_ready);
   assign req_ready  = !in_valid_ff || step;
   assign snap_valid = in_valid_ff && in_ff.line_end;

   always_comb begin
      field_in = field_ff;
      tok_in   = tok_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      hc_in    = hc_ff;
      ended_in = ended_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      dec_in   = dec_ff;
      is_dec   = 1'b0;
      slot     = 3'd0;
      mag      = 36'd0;
      idx      = '0;
      if (!ended_ff) begin
         if (b == prtp_pkg::CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (b == prtp_pkg::CHAR_SEMI) begin
            tok_in = 1'b0;
         end else begin
            if (!tok_ff) begin
               tok_in = 1'b1;
               if (field_ff < prtp_pkg::FIELD_MAX) field_in = field_ff + 4'd1;
               acc_in   = 32'd0;
               phase_in = prtp_pkg::PH_SKIP;
               neg_in   = 1'b0;
               hc_in    = 7'd0;
            end
            case (field_in)
               prtp_pkg::FIELD_TIME:    begin is_dec = 1'b1; slot = 3'd0; end
               prtp_pkg::FIELD_LAT:     begin is_dec = 1'b1; slot = 3'd1; end
               prtp_pkg::FIELD_LON:     begin is_dec = 1'b1; slot = 3'd2; end
               prtp_pkg::FIELD_SPEED:   begin is_dec = 1'b1; slot = 3'd3; end
               prtp_pkg::FIELD_HEADING: begin is_dec = 1'b1; slot = 3'd4; end
               default:                 begin is_dec = 1'b0; slot = 3'd0; end
            endcase
            if (field_in == prtp_pkg::FIELD_ID) begin
               idx = hc_in[prtp_pkg::ID_IDX_W:1];
               if (hc_in < prtp_pkg::HEX_LIMIT) begin
                  if (!hc_in[0]) begin
                     hi_in[idx] = nibble_of(b);
                     lo_in[idx] = 4'd0;
                  end else begin
                     lo_in[idx] = nibble_of(b);
                  end
               end
               if (hc_in < prtp_pkg::HEX_SAT) hc_in = hc_in + 7'd1;
            end else if (is_dec && phase_in != prtp_pkg::PH_DONE) begin
               if (phase_in == prtp_pkg::PH_SKIP &&
                   (b == prtp_pkg::CHAR_SPACE || (b >= 8'h09 && b <= 8'h0D))) begin
                  phase_in = prtp_pkg::PH_SKIP;
               end else if (phase_in == prtp_pkg::PH_SKIP &&
                            (b == prtp_pkg::CHAR_PLUS || b == prtp_pkg::CHAR_MINUS)) begin
                  neg_in   = (b == prtp_pkg::CHAR_MINUS);
                  phase_in = prtp_pkg::PH_DIGITS;
               end else if (b < 8'h30 || b > 8'h39) begin
                  phase_in = prtp_pkg::PH_DONE;
               end else begin
                  phase_in = prtp_pkg::PH_DIGITS;
                  mag = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                        + {32'd0, 4'(b - 8'h30)};
                  acc_in = (mag > 36'h080000000) ? 32'h80000000 : mag[31:0];
                  if (neg_in) dec_in[slot] = 32'd0 - acc_in;
                  else dec_in[slot] = acc_in[31] ? 32'h7FFFFFFF : acc_in;
               end
            end
         end
      end
   end

   always_comb begin
      snap_data.record_valid = (field_in >= prtp_pkg::FIELD_MIN_OK);
      snap_data.dec          = dec_in;
      for (int i = 0; i < prtp_pkg::ID_SLOTS; i++) begin
         snap_data.id[i] = {hi_in[i], lo_in[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) in_ff <= req_data;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_ff.line_end)) begin
         field_ff <= 4'd0;
         tok_ff   <= 1'b0;
         acc_ff   <= 32'd0;
         phase_ff <= prtp_pkg::PH_SKIP;
         neg_ff   <= 1'b0;
         hc_ff    <= 7'd0;
         ended_ff <= 1'b0;
         hi_ff    <= '0;
         lo_ff    <= '0;
         dec_ff   <= '0;
      end else if (step) begin
         field_ff <= field_in;
         tok_ff   <= tok_in;
         acc_ff   <= acc_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         hc_ff    <= hc_in;
         ended_ff <= ended_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         dec_ff   <= dec_in;
      end
   end

endmodule

// ----- rtl/prtp_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtp_emitter
// Holds one record snapshot and sends it as four identifier slices, or as a
// single invalid result.
// ----------------------------------------------------------------------------
module prtp_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               snap_valid,
   output logic               snap_ready,
   input  prtp_pkg::snap_type snap_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output prtp_pkg::rsp_type  rsp_data
);

   logic               busy_ff;
   logic [1:0]         chunk_ff;
   prtp_pkg::snap_type snap_ff;
   logic               last;
   logic [63:0]        chunk;

   assign last       = !snap_ff.record_valid || (chunk_ff == 2'd3);
   assign rsp_valid  = busy_ff;
   assign snap_ready = !busy_ff || (rsp_ready && last);

   always_comb begin
      for (int j = 0; j < prtp_pkg::CHUNK_BYTES; j++) begin
         chunk[63 - 8 * j -: 8] = snap_ff.id[{chunk_ff, 3'(j)}];
      end
   end

   always_comb begin
      rsp_data.record_valid  = snap_ff.record_valid;
      rsp_data.time_stamp    = snap_ff.record_valid ? snap_ff.dec[0] : 32'sd0;
      rsp_data.latitude_raw  = snap_ff.record_valid ? snap_ff.dec[1] : 32'sd0;
      rsp_data.longitude_raw = snap_ff.record_valid ? snap_ff.dec[2] : 32'sd0;
      rsp_data.speed_value   = snap_ff.record_valid ? snap_ff.dec[3] : 32'sd0;
      rsp_data.heading_value = snap_ff.record_valid ? snap_ff.dec[4] : 32'sd0;
      rsp_data.id_chunk      = snap_ff.record_valid ? chunk : 64'd0;
      rsp_data.chunk_index   = chunk_ff;
      rsp_data.last          = last;
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) snap_ff <= snap_data;
      if (reset) begin
         busy_ff  <= 1'b0;
         chunk_ff <= 2'd0;
      end else if (snap_valid && snap_ready) begin
         busy_ff  <= 1'b1;
         chunk_ff <= 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (last) busy_ff <= 1'b0;
         else chunk_ff <= chunk_ff + 2'd1;
      end
   end

endmodule

// ----- rtl/probe_record_text_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_record_text_parser
// Parses semicolon separated probe record lines, one byte per transfer, and
// emits the decoded record with its identifier in 64-bit slices.
// ----------------------------------------------------------------------------
//  channel  dir  payload              transfer
//  req      in   prtp_pkg::req_type   req_valid && req_ready
//  rsp      out  prtp_pkg::rsp_type   rsp_valid && rsp_ready
//
//  one byte per cycle: the parser state updates from the input register
//  a line end hands a snapshot to the output stage, which sends four slices
//  (one when invalid); the next line end stalls until that stage drains
//  synchronous reset clears the parse state and both valid flags
//  rsp stalls back up into req only at a line end byte
// ----------------------------------------------------------------------------
module probe_record_text_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prtp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prtp_pkg::rsp_type rsp_data
);

   logic               snap_valid;
   logic               snap_ready;
   prtp_pkg::snap_type snap_data;

   prtp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   prtp_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
